@@ rtl/csfs_pkg.sv @@
// package for the sender frame sequencer: payload types, codes and constants
package csfs_pkg;

  localparam int unsigned SENT_CAP = 128;
  localparam int unsigned SEQ_W    = 8;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned WIN_W    = 7;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNCH_TIMEOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_ON_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    OP_FRAME_REQUEST = 2'd0,
    OP_STATUS_REPORT = 2'd1,
    OP_TICK          = 2'd2,
    OP_RESET         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEND_NONE      = 2'd0,
    SEND_EXPEDITED = 2'd1,
    SEND_RESEND    = 2'd2,
    SEND_NEW       = 2'd3
  } send_kind_t;

  typedef struct packed {
    op_t               operation;
    logic              expedited_ready;
    logic              sequenced_ready;
    logic [SEQ_W-1:0]  report_number;
    logic              report_retransmit;
    logic              report_format_ok;
    logic [TIME_W-1:0] time_now;
  } in_t;

  typedef struct packed {
    send_kind_t       send_kind;
    logic [SEQ_W-1:0] frame_number;
    logic             report_accepted;
    logic             timer_expired;
    logic             in_resync;
    logic [CNT_W-1:0] outstanding;
  } out_t;

endpackage

@@ rtl/cop_sender_frame_sequencer_core.sv @@
// top level of the sender frame sequencer: input register, state update, result register
//
// One transaction in, one result out. An accepted item sits in the input
// register, is resolved against the protocol state by a single pass of compare and
// add logic, and lands in the result register together with the state update, so
// items are taken back to back at one per cycle unless out_ready stalls the
// result register, a rate set by the sequence state loop. Configuration writes are
// always taken (cfg_ready is tied high) and must be issued only while the block is idle.
module cop_sender_frame_sequencer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csfs_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csfs_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned SW = csfs_pkg::SEQ_W;
  localparam int unsigned CW = csfs_pkg::CNT_W;
  localparam int unsigned TW = csfs_pkg::TIME_W;
  localparam int unsigned WW = csfs_pkg::WIN_W;
  localparam logic [CW-1:0] CAP = CW'(csfs_pkg::SENT_CAP);

  function automatic logic seq_before(logic [SW-1:0] a, logic [SW-1:0] b);
    logic [SW-1:0] d;
    d = b - a;
    return (d != '0) && !d[SW-1];
  endfunction

  // configuration
  logic [WW-1:0] window_size_r;
  logic [TW-1:0] synch_timeout_r;
  logic          resync_on_timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r       <= WW'(1);
      synch_timeout_r     <= '0;
      resync_on_timeout_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csfs_pkg::CFG_WINDOW_SIZE: begin
          window_size_r <= (cfg_data[WW-1:0] == '0) ? WW'(1) : cfg_data[WW-1:0];
        end
        csfs_pkg::CFG_SYNCH_TIMEOUT: begin
          synch_timeout_r <= cfg_data[TW-1:0];
        end
        csfs_pkg::CFG_RESYNC_ON_TIMEOUT: begin
          resync_on_timeout_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // handshake and pipeline registers
  logic           s1_valid_r;
  csfs_pkg::in_t  s1_data_r;
  logic           out_valid_r;
  csfs_pkg::out_t out_data_r;
  logic           advance;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // protocol state
  logic [SW-1:0] next_seq_number_r, next_seq_number_nxt;
  logic [SW-1:0] next_exp_number_r, next_exp_number_nxt;
  logic [SW-1:0] resend_pointer_r, resend_pointer_nxt;
  logic [SW-1:0] acked_number_r, acked_number_nxt;
  logic          stored_rt_r, stored_rt_nxt;
  logic          resync_mode_r, resync_mode_nxt;
  logic [CW-1:0] outstanding_r, outstanding_nxt;
  logic [SW-1:0] last_frame_r, last_frame_nxt;
  logic          timer_running_r, timer_running_nxt;
  logic [TW-1:0] timer_deadline_r, timer_deadline_nxt;
  csfs_pkg::out_t result;

  logic [SW-1:0] nr;
  logic          rt;
  logic          report_ok;
  logic [SW-1:0] ack_dist;
  logic [SW-1:0] win_dist;

  always_comb begin
    next_seq_number_nxt = next_seq_number_r;
    next_exp_number_nxt = next_exp_number_r;
    resend_pointer_nxt  = resend_pointer_r;
    acked_number_nxt    = acked_number_r;
    stored_rt_nxt       = stored_rt_r;
    resync_mode_nxt     = resync_mode_r;
    outstanding_nxt     = outstanding_r;
    last_frame_nxt      = last_frame_r;
    timer_running_nxt   = timer_running_r;
    timer_deadline_nxt  = timer_deadline_r;
    result              = '0;
    result.send_kind    = csfs_pkg::SEND_NONE;

    nr       = s1_data_r.report_number;
    rt       = s1_data_r.report_retransmit;
    ack_dist = nr - acked_number_r;
    win_dist = next_seq_number_r - acked_number_r;
    report_ok = s1_data_r.report_format_ok
             && !seq_before(nr, acked_number_r)
             && !seq_before(next_seq_number_r, nr)
             && !(rt && (nr == next_seq_number_r))
             && !(!rt && stored_rt_r && (nr == acked_number_r));

    unique case (s1_data_r.operation)
      csfs_pkg::OP_FRAME_REQUEST: begin
        if (!resync_mode_r) begin
          priority if (s1_data_r.expedited_ready) begin
            last_frame_nxt      = next_exp_number_r;
            next_exp_number_nxt = next_exp_number_r + SW'(1);
            result.send_kind    = csfs_pkg::SEND_EXPEDITED;
          end else if (seq_before(resend_pointer_r, next_seq_number_r)) begin
            last_frame_nxt     = resend_pointer_r;
            resend_pointer_nxt = resend_pointer_r + SW'(1);
            result.send_kind   = csfs_pkg::SEND_RESEND;
          end else if (s1_data_r.sequenced_ready && (win_dist < SW'(window_size_r))
                       && (outstanding_r < CAP)) begin
            last_frame_nxt      = next_seq_number_r;
            outstanding_nxt     = outstanding_r + CW'(1);
            next_seq_number_nxt = next_seq_number_r + SW'(1);
            resend_pointer_nxt  = resend_pointer_r + SW'(1);
            result.send_kind    = csfs_pkg::SEND_NEW;
          end else if (seq_before(acked_number_r, next_seq_number_r)) begin
            last_frame_nxt     = acked_number_r;
            resend_pointer_nxt = acked_number_r + SW'(1);
            result.send_kind   = csfs_pkg::SEND_RESEND;
          end else begin
          end
        end
      end
      csfs_pkg::OP_STATUS_REPORT: begin
        if (!report_ok) begin
          if (!resync_mode_r) begin
            if (!timer_running_r) begin
              timer_running_nxt  = 1'b1;
              timer_deadline_nxt = '0;
            end
            resend_pointer_nxt = acked_number_r;
          end
        end else begin
          if (seq_before(acked_number_r, nr)) begin
            outstanding_nxt = (CW'(ack_dist) > outstanding_r) ? '0
                            : outstanding_r - CW'(ack_dist);
          end
          if (rt || seq_before(resend_pointer_r, nr)) begin
            resend_pointer_nxt = nr;
          end
          acked_number_nxt   = nr;
          stored_rt_nxt      = rt;
          timer_running_nxt  = 1'b0;
          timer_deadline_nxt = '0;
          if (resync_mode_r && !rt && (nr == acked_number_r)) begin
            resync_mode_nxt = 1'b0;
          end
          result.report_accepted = 1'b1;
        end
      end
      csfs_pkg::OP_TICK: begin
        if (timer_running_r && (synch_timeout_r != '0)) begin
          if (timer_deadline_r == '0) begin
            timer_deadline_nxt = s1_data_r.time_now + synch_timeout_r;
          end else if (s1_data_r.time_now >= timer_deadline_r) begin
            timer_running_nxt  = 1'b0;
            timer_deadline_nxt = '0;
            if (!resync_mode_r && resync_on_timeout_r) begin
              stored_rt_nxt   = 1'b0;
              resync_mode_nxt = 1'b1;
            end
            result.timer_expired = 1'b1;
          end else begin
          end
        end
      end
      csfs_pkg::OP_RESET: begin
        next_seq_number_nxt = '0;
        next_exp_number_nxt = '0;
        resend_pointer_nxt  = '0;
        acked_number_nxt    = '0;
        stored_rt_nxt       = 1'b0;
        resync_mode_nxt     = 1'b0;
        outstanding_nxt     = '0;
        last_frame_nxt      = '0;
        timer_running_nxt   = 1'b0;
        timer_deadline_nxt  = '0;
      end
      default: begin
      end
    endcase

    result.frame_number = last_frame_nxt;
    result.in_resync    = resync_mode_nxt;
    result.outstanding  = outstanding_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      next_seq_number_r <= '0;
      next_exp_number_r <= '0;
      resend_pointer_r  <= '0;
      acked_number_r    <= '0;
      stored_rt_r       <= 1'b0;
      resync_mode_r     <= 1'b0;
      outstanding_r     <= '0;
      last_frame_r      <= '0;
      timer_running_r   <= 1'b0;
      timer_deadline_r  <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        next_seq_number_r <= next_seq_number_nxt;
        next_exp_number_r <= next_exp_number_nxt;
        resend_pointer_r  <= resend_pointer_nxt;
        acked_number_r    <= acked_number_nxt;
        stored_rt_r       <= stored_rt_nxt;
        resync_mode_r     <= resync_mode_nxt;
        outstanding_r     <= outstanding_nxt;
        last_frame_r      <= last_frame_nxt;
        timer_running_r   <= timer_running_nxt;
        timer_deadline_r  <= timer_deadline_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance && s1_valid_r) begin
      out_data_r <= result;
    end
  end

endmodule
